@@ rtl/oorf_pkg.sv @@
// Package for the overwrite-oldest record FIFO: word types, action codes,
// default sizes and the command/status structs between controller and datapath.
// No dependencies.
package oorf_pkg;

    localparam int DEPTH_DEF        = 64;
    localparam int RECORD_WIDTH_DEF = 64;
    localparam int MAX_RESULTS      = 64;
    localparam int POP_W            = 7;

    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_POP   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]       action;
        logic [63:0]      record_in;
        logic [POP_W-1:0] pop_limit;
    } oorf_in_t;

    typedef struct packed {
        logic [63:0] record_out;
        logic        record_valid;
        logic        last;
        logic        kept_all;
        logic [6:0]  occupancy;
        logic        ring_empty;
        logic [31:0] dropped_total;
    } oorf_out_t;

    typedef struct packed {
        logic do_push;
        logic do_clear;
        logic start_pop;
        logic load_status;
        logic issue_read;
        logic load_record;
    } oorf_cmd_t;

    typedef struct packed {
        logic out_full;
        logic pop_nonzero;
        logic issue_pending;
        logic data_avail;
        logic emit_last;
    } oorf_status_t;

endpackage

@@ rtl/oorf_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module oorf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/oorf_ctrl.sv @@
// Controller for the overwrite-oldest record FIFO: decodes accepted words and
// sequences block pops. Depends on oorf_pkg.
module oorf_ctrl
    import oorf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [1:0]   in_action,
    input  logic         out_ready,
    input  oorf_status_t status,
    output oorf_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_POP  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_free;
    logic   accept;

    assign out_free = !status.out_full || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        accept     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = out_free;
                accept   = in_valid && out_free;
                if (accept)
                begin
                    unique case (in_action)
                        ACT_PUSH:
                        begin
                            cmd.do_push     = 1'b1;
                            cmd.load_status = 1'b1;
                        end
                        ACT_CLEAR:
                        begin
                            cmd.do_clear    = 1'b1;
                            cmd.load_status = 1'b1;
                        end
                        ACT_POP:
                        begin
                            if (status.pop_nonzero)
                            begin
                                cmd.start_pop = 1'b1;
                                state_next    = S_POP;
                            end
                            else
                            begin
                                cmd.load_status = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd.load_status = 1'b1;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                // While reads remain to be issued, a read is issued whenever the read data
                // register is free or is being emptied into the output register this cycle.
                cmd.load_record = status.data_avail && out_free;
                cmd.issue_read  = status.issue_pending
                                  && (!status.data_avail || cmd.load_record);
                if (cmd.load_record && status.emit_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/oorf_dpath.sv @@
// Datapath for the overwrite-oldest record FIFO: pointers, occupancy, dropped
// counter, pop counters, record RAM and the output register.
// Depends on oorf_pkg and oorf_ram.
module oorf_dpath
    import oorf_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int RECORD_WIDTH = RECORD_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  oorf_in_t     in_data,
    input  logic         out_ready,
    input  oorf_cmd_t    cmd,
    output oorf_status_t status,
    output logic         out_valid,
    output oorf_out_t    out_data
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int CMP_W  = (FILL_W > POP_W) ? FILL_W : POP_W;

    logic [PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic [31:0]             drop_reg, drop_next;
    logic [POP_W-1:0]        issue_left_reg, issue_left_next;
    logic [POP_W-1:0]        emit_left_reg, emit_left_next;
    logic                    data_avail_reg, data_avail_next;
    logic                    out_valid_reg;
    oorf_out_t               out_reg;
    logic                    full;
    logic [POP_W-1:0]        limit_cap;
    logic [POP_W-1:0]        pop_n;
    logic [RECORD_WIDTH-1:0] rd_data;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full = (fill_reg == FILL_W'(DEPTH));

    // Records emitted by a pop: the least of the limit, the occupancy and
    // the bound on results for one word.
    always_comb
    begin
        limit_cap = (in_data.pop_limit > POP_W'(MAX_RESULTS))
                    ? POP_W'(MAX_RESULTS) : in_data.pop_limit;
        pop_n = (CMP_W'(fill_reg) < CMP_W'(limit_cap))
                ? POP_W'(fill_reg) : limit_cap;
    end

    always_comb
    begin
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        fill_next       = fill_reg;
        drop_next       = drop_reg;
        issue_left_next = issue_left_reg;
        emit_left_next  = emit_left_reg;
        if (cmd.do_push)
        begin
            wr_ptr_next = advance(wr_ptr_reg);
            if (full)
            begin
                rd_ptr_next = advance(rd_ptr_reg);
                drop_next   = drop_reg + 32'd1;
            end
            else
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
        if (cmd.do_clear)
        begin
            wr_ptr_next = '0;
            rd_ptr_next = '0;
            fill_next   = '0;
            drop_next   = '0;
        end
        if (cmd.start_pop)
        begin
            fill_next       = fill_reg - FILL_W'(pop_n);
            issue_left_next = pop_n;
            emit_left_next  = pop_n;
        end
        if (cmd.issue_read)
        begin
            rd_ptr_next     = advance(rd_ptr_reg);
            issue_left_next = issue_left_reg - POP_W'(1);
        end
        if (cmd.load_record)
        begin
            emit_left_next = emit_left_reg - POP_W'(1);
        end
        if (cmd.issue_read)
        begin
            data_avail_next = 1'b1;
        end
        else if (cmd.load_record)
        begin
            data_avail_next = 1'b0;
        end
        else
        begin
            data_avail_next = data_avail_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fill_reg       <= '0;
            drop_reg       <= '0;
            issue_left_reg <= '0;
            emit_left_reg  <= '0;
            data_avail_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            fill_reg       <= fill_next;
            drop_reg       <= drop_next;
            issue_left_reg <= issue_left_next;
            emit_left_reg  <= emit_left_next;
            data_avail_reg <= data_avail_next;
            if (cmd.load_status || cmd.load_record)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Status results show the state after the word; record results during a
    // pop show the occupancy already reduced by the whole block.
    always_ff @(posedge clk)
    begin
        if (cmd.load_status)
        begin
            out_reg.record_out    <= '0;
            out_reg.record_valid  <= 1'b0;
            out_reg.last          <= 1'b1;
            out_reg.kept_all      <= !(cmd.do_push && full);
            out_reg.occupancy     <= 7'(fill_next);
            out_reg.ring_empty    <= (fill_next == '0);
            out_reg.dropped_total <= drop_next;
        end
        else if (cmd.load_record)
        begin
            out_reg.record_out    <= 64'(rd_data);
            out_reg.record_valid  <= 1'b1;
            out_reg.last          <= (emit_left_reg == POP_W'(1));
            out_reg.kept_all      <= 1'b1;
            out_reg.occupancy     <= 7'(fill_reg);
            out_reg.ring_empty    <= (fill_reg == '0);
            out_reg.dropped_total <= drop_reg;
        end
    end

    oorf_ram #(
        .WIDTH (RECORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.do_push),
        .wr_addr (wr_ptr_reg),
        .wr_data (in_data.record_in[RECORD_WIDTH-1:0]),
        .rd_en   (cmd.issue_read),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_data)
    );

    assign status.out_full      = out_valid_reg;
    assign status.pop_nonzero   = (pop_n != '0);
    assign status.issue_pending = (issue_left_reg != '0);
    assign status.data_avail    = data_avail_reg;
    assign status.emit_last     = (emit_left_reg == POP_W'(1));

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ rtl/overwrite_oldest_record_fifo.sv @@
// Top level of the overwrite-oldest record FIFO.
// Depends on oorf_pkg, oorf_ctrl, oorf_dpath and oorf_ram.
//
// A ring buffer of DEPTH records that never refuses a push: when full, a push
// discards the oldest record, counts it in a wrapping 32-bit dropped total
// and reports kept_all low. Push, clear and unused action words each give one
// status word, so they can be accepted every cycle while the output register
// keeps draining. A pop block that emits n records (the least of pop_limit, the
// occupancy and 64) runs as: the cycle that accepts the word, the registered
// read of the first record from the record RAM, then one record per cycle while
// the output is not stalled; after the pop is accepted, in_ready stays low until
// the last record is loaded into the output register. A pop that can emit
// nothing gives one empty word with last set. Every output word carries the
// occupancy after the word, an empty flag and the dropped total. The record RAM
// needs no clearing; entries are only read after being written.
module overwrite_oldest_record_fifo
    import oorf_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int RECORD_WIDTH = RECORD_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  oorf_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output oorf_out_t out_data
);

    oorf_cmd_t    cmd;
    oorf_status_t status;

    oorf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_action (in_data.action),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    oorf_dpath #(
        .DEPTH        (DEPTH),
        .RECORD_WIDTH (RECORD_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule
